@@ rtl/lpd_pkg.sv @@
// shared types and constants for the length prefix deframer
`default_nettype none

package lpd_pkg;

    localparam int unsigned LPD_HEADER_BYTES   = 4;
    localparam logic [31:0] LPD_RESET_MAX      = 32'd10485760;
    localparam int unsigned LPD_QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_NEG_LEN  = 2'd2,
        KIND_TOO_LONG = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic       first_of_frame;
        logic       last_of_frame;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/length_prefix_deframer.sv @@
// top level of the length prefix deframer
//
// Splits a byte stream into frames that each open with a 4-byte big-endian
// signed length. Input channel: i_in_valid / o_in_stall carry one stream
// byte and a restart flag per transfer. Output channel: o_out_valid /
// i_out_stall carry one result per transfer: a payload byte with first and
// last marks, an empty-frame mark, or a length error. Header bytes give
// no result except on the fourth byte. After an error every byte is
// dropped until a transfer with restart set, whose byte starts a new
// header. Config channel: i_cfg_valid / o_cfg_ready writes the frame size
// limit (header included); o_cfg_ready is always high.
// One byte is taken every cycle while o_in_stall is low. A result enters the
// queue at the edge that takes its byte and is then popped into the output
// register. A queue of QUEUE_DEPTH results sits in front of that register;
// o_in_stall rises only when the queue is full, which needs a receiver stall.
// Reset (synchronous, active low) empties the queue, returns to header
// collection and sets the limit to 10485760.
`default_nettype none

module length_prefix_deframer
    import lpd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = LPD_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_restart,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_payload_byte,
    output logic             o_first_of_frame,
    output logic             o_last_of_frame
);

    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    logic    front_push;
    logic    in_accept;
    t_result front_result;
    t_result q_data;
    t_result out_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    lpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .o_result    (front_result),
        .o_push      (front_push)
    );

    lpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_push_data (front_result),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_data),
        .o_empty     (q_empty)
    );

    lpd_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_result  (out_result)
    );

    assign o_result_kind    = out_result.kind;
    assign o_payload_byte   = out_result.payload_byte;
    assign o_first_of_frame = out_result.first_of_frame;
    assign o_last_of_frame  = out_result.last_of_frame;

endmodule

`default_nettype wire

@@ rtl/lpd_front.sv @@
// header assembly, length checks and payload countdown
`default_nettype none

module lpd_front
    import lpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_restart,
    output t_result          o_result,
    output logic             o_push
);

    t_phase       r_phase, n_phase;
    logic [1:0]   r_hdr_cnt, n_hdr_cnt;
    logic [31:0]  r_len_shift, n_len_shift;
    logic [30:0]  r_remaining, n_remaining;
    logic         r_at_start, n_at_start;
    logic [31:0]  r_max_frame_bytes;

    t_phase       eff_phase;
    logic [1:0]   eff_hdr_cnt;
    logic [31:0]  eff_len_shift;
    logic [30:0]  eff_remaining;
    logic         eff_at_start;
    logic [31:0]  new_len;
    logic         too_long;
    logic         is_last;

    // restart returns to header collection before the byte is taken
    always_comb begin
        eff_phase     = i_restart ? PH_HEADER : r_phase;
        eff_hdr_cnt   = i_restart ? 2'd0      : r_hdr_cnt;
        eff_len_shift = i_restart ? 32'd0     : r_len_shift;
        eff_remaining = i_restart ? 31'd0     : r_remaining;
        eff_at_start  = i_restart ? 1'b1      : r_at_start;
    end

    assign new_len  = {eff_len_shift[23:0], i_data_byte};
    assign too_long = ({1'b0, new_len} + 33'(LPD_HEADER_BYTES)) > {1'b0, r_max_frame_bytes};
    assign is_last  = (eff_remaining <= 31'd1);

    // next state
    always_comb begin
        n_phase     = eff_phase;
        n_hdr_cnt   = eff_hdr_cnt;
        n_len_shift = eff_len_shift;
        n_remaining = eff_remaining;
        n_at_start  = eff_at_start;
        case (eff_phase)
            PH_HEADER: begin
                n_len_shift = new_len;
                if (eff_hdr_cnt != 2'(LPD_HEADER_BYTES - 1)) begin
                    n_hdr_cnt = eff_hdr_cnt + 2'd1;
                end else begin
                    n_hdr_cnt = 2'd0;
                    if (new_len[31] || too_long) begin
                        n_phase = PH_ERROR;
                    end else if (new_len == 32'd0) begin
                        n_len_shift = 32'd0;
                        n_remaining = 31'd0;
                        n_at_start  = 1'b1;
                    end else begin
                        n_remaining = new_len[30:0];
                        n_len_shift = 32'd0;
                        n_at_start  = 1'b1;
                        n_phase     = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_at_start = 1'b0;
                if (is_last) begin
                    n_phase     = PH_HEADER;
                    n_hdr_cnt   = 2'd0;
                    n_len_shift = 32'd0;
                    n_remaining = 31'd0;
                    n_at_start  = 1'b1;
                end else begin
                    n_remaining = eff_remaining - 31'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // result of this byte
    always_comb begin
        o_push   = 1'b0;
        o_result = '{kind: KIND_PAYLOAD, payload_byte: 8'd0,
                     first_of_frame: 1'b0, last_of_frame: 1'b0};
        case (eff_phase)
            PH_HEADER: begin
                if (eff_hdr_cnt == 2'(LPD_HEADER_BYTES - 1)) begin
                    o_push = i_accept;
                    if (new_len[31]) begin
                        o_result.kind = KIND_NEG_LEN;
                    end else if (too_long) begin
                        o_result.kind = KIND_TOO_LONG;
                    end else if (new_len == 32'd0) begin
                        o_result.kind          = KIND_EMPTY;
                        o_result.last_of_frame = 1'b1;
                    end else begin
                        o_push = 1'b0;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_push                  = i_accept;
                o_result.payload_byte   = i_data_byte;
                o_result.first_of_frame = eff_at_start;
                o_result.last_of_frame  = is_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_HEADER;
            r_hdr_cnt         <= 2'd0;
            r_len_shift       <= 32'd0;
            r_remaining       <= 31'd0;
            r_at_start        <= 1'b1;
            r_max_frame_bytes <= LPD_RESET_MAX;
        end else begin
            if (i_cfg_valid) begin
                r_max_frame_bytes <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase     <= n_phase;
                r_hdr_cnt   <= n_hdr_cnt;
                r_len_shift <= n_len_shift;
                r_remaining <= n_remaining;
                r_at_start  <= n_at_start;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/lpd_queue.sv @@
// short result queue between the front and the output stage
`default_nettype none

module lpd_queue
    import lpd_pkg::*;
#(
    parameter int unsigned DEPTH = LPD_QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_push_data,
    output logic         o_full,
    input  wire logic    i_pop,
    output t_result      o_pop_data,
    output logic         o_empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/lpd_out_reg.sv @@
// output register driving the result channel
`default_nettype none

module lpd_out_reg
    import lpd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_empty,
    input  wire t_result i_q_data,
    output logic         o_q_pop,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_q_pop  = !i_q_empty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_result <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ verif/length_prefix_deframer_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the length prefix deframer
module length_prefix_deframer_tb;
    import lpd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_restart = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_payload_byte;
    logic        o_first_of_frame;
    logic        o_last_of_frame;

    length_prefix_deframer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_payload_byte   (o_payload_byte),
        .o_first_of_frame (o_first_of_frame),
        .o_last_of_frame  (o_last_of_frame)
    );

    // deframer state as tracked by the testbench
    t_phase      ph;
    int unsigned hdr_cnt;
    logic [31:0] len_acc;
    logic [30:0] remaining;
    logic        first_pending;
    logic [31:0] frame_limit;
    t_result     pending_results[$];

    int bytes_sent      = 0;
    int results_checked = 0;
    int error_count     = 0;
    int limits_written  = 0;

    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int hold_trigger  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    always #5 i_clk = ~i_clk;

    function automatic void restart_frame();
        ph            = PH_HEADER;
        hdr_cnt       = 0;
        len_acc       = '0;
        remaining     = '0;
        first_pending = 1'b1;
    endfunction

    function automatic void expect_result(input t_kind kind, input logic [7:0] b,
                                          input logic is_first, input logic is_last);
        t_result r;
        r.kind           = kind;
        r.payload_byte   = b;
        r.first_of_frame = is_first;
        r.last_of_frame  = is_last;
        pending_results.push_back(r);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic rs);
        logic [32:0] total;
        logic        at_end;
        if (rs) begin
            restart_frame();
        end
        case (ph)
            PH_HEADER: begin
                len_acc = {len_acc[23:0], b};
                hdr_cnt = hdr_cnt + 1;
                if (hdr_cnt == LPD_HEADER_BYTES) begin
                    hdr_cnt = 0;
                    // 33-bit sum so a huge length cannot wrap past the limit
                    total = {1'b0, len_acc} + 33'(LPD_HEADER_BYTES);
                    if (len_acc[31]) begin
                        ph = PH_ERROR;
                        expect_result(KIND_NEG_LEN, 8'h00, 1'b0, 1'b0);
                    end else if (total > {1'b0, frame_limit}) begin
                        ph = PH_ERROR;
                        expect_result(KIND_TOO_LONG, 8'h00, 1'b0, 1'b0);
                    end else if (len_acc == '0) begin
                        restart_frame();
                        expect_result(KIND_EMPTY, 8'h00, 1'b0, 1'b1);
                    end else begin
                        remaining     = len_acc[30:0];
                        len_acc       = '0;
                        first_pending = 1'b1;
                        ph            = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                at_end = (remaining <= 31'd1);
                expect_result(KIND_PAYLOAD, b, first_pending, at_end);
                first_pending = 1'b0;
                if (at_end) begin
                    restart_frame();
                end else begin
                    remaining = remaining - 31'd1;
                end
            end
            default: ;
        endcase
    endfunction

    // receiver stall, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen   <= hold_trigger;
            hold_left   <= 40;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer, result_kind %0d", o_result_kind);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, o_result_kind);
                    error_count++;
                end
                if (o_payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %0h, actual %0h",
                           want.payload_byte, o_payload_byte);
                    error_count++;
                end
                if (o_first_of_frame !== want.first_of_frame) begin
                    $error("first_of_frame: expected %0b, actual %0b",
                           want.first_of_frame, o_first_of_frame);
                    error_count++;
                end
                if (o_last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame: expected %0b, actual %0b",
                           want.last_of_frame, o_last_of_frame);
                    error_count++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic rs);
        while ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_restart   <= rs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        deframe_byte(b, rs);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [31:0] len, input logic rs);
        send_byte(len[31:24], rs);
        send_byte(len[23:16], 1'b0);
        send_byte(len[15:8], 1'b0);
        send_byte(len[7:0], 1'b0);
    endtask

    task automatic send_payload(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // drop valid and wait until every result is out and the pipeline is empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        frame_limit = v;
        limits_written++;
    endtask

    function automatic logic needs_restart();
        return (ph != PH_HEADER) || (hdr_cnt != 0);
    endfunction

    task automatic send_random_frame();
        int unsigned pick;
        logic [31:0] room;
        logic [31:0] len;
        logic        rs;
        pick = $urandom_range(99);
        rs   = needs_restart() || ($urandom_range(19) == 0);
        room = frame_limit - 32'd4;
        if (pick >= 70 && pick < 82 && room >= 32'h7fffffff) begin
            pick = 82;
        end
        if (pick < 70) begin
            if (pick < 7 || room == 0) begin
                len = 32'd0;
            end else begin
                len = $urandom_range((room > 32'd16) ? 32'd16 : room, 1);
            end
            send_header(len, rs);
            send_payload(len);
        end else if (pick < 82) begin
            if (pick < 74) begin
                len = room + 32'd1;
            end else begin
                len = $urandom_range(32'h7fffffff, room + 32'd1);
            end
            send_header(len, rs);
            send_payload($urandom_range(3));
        end else if (pick < 92) begin
            len = {1'b1, 31'($urandom)};
            send_header(len, rs);
            send_payload($urandom_range(3));
        end else if (pick[0]) begin
            // header cut short
            for (int i = $urandom_range(3, 1); i > 0; i--) begin
                send_byte(8'($urandom_range(255)), rs);
                rs = 1'b0;
            end
        end else begin
            // payload cut short
            len = $urandom_range(12, 4);
            send_header(len, rs);
            send_payload($urandom_range(len - 1, 1));
        end
    endtask

    task automatic test_frame_basics();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        send_header(32'd0, 1'b0);
        send_header(32'd2, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_length_errors();
        send_header(32'h8000_0000, 1'b0);
        send_byte(8'h55, 1'b0);
        send_header(32'h7fff_ffff, 1'b1);
    endtask

    task automatic test_limit_extremes();
        wait_idle();
        write_limit(32'd4);
        send_header(32'd0, 1'b1);
        send_header(32'd1, 1'b0);
        wait_idle();
        write_limit(32'h8000_0003);
        send_header(32'h7fff_ffff, 1'b1);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_header(32'd0, 1'b1);
    endtask

    task automatic test_output_hold();
        wait_idle();
        write_limit(LPD_RESET_MAX);
        in_gap_pct    = 0;
        out_stall_pct = 0;
        hold_trigger++;
        send_header(32'd40, needs_restart());
        send_payload(40);
        wait_idle();
    endtask

    task automatic test_pause_mid_frame();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        send_header(32'd12, needs_restart());
        send_payload(6);
        wait_idle();
        send_payload(6);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n, input int gap, input int stall,
                                       input logic [31:0] limit);
        int stop_at;
        wait_idle();
        write_limit(limit);
        in_gap_pct    = gap;
        out_stall_pct = stall;
        stop_at       = bytes_sent + n;
        while (bytes_sent < stop_at) send_random_frame();
        wait_idle();
    endtask

    initial begin
        restart_frame();
        frame_limit = LPD_RESET_MAX;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_frame_basics();
        test_length_errors();
        test_limit_extremes();
        test_output_hold();
        test_pause_mid_frame();
        test_random_traffic(240, 0, 0, LPD_RESET_MAX);
        test_random_traffic(240, 63, 0, 32'd4 + $urandom_range(28));
        test_random_traffic(240, 0, 63, 32'h8000_0003);
        test_random_traffic(240, 37, 37, 32'd20 + $urandom_range(40));
        test_random_traffic(60, 37, 37, 32'd4);

        out_stall_pct = 0;
        wait_idle();
        $display("checked %0d results from %0d input bytes over %0d limit writes",
                 results_checked, bytes_sent, limits_written);
        $display("traffic mixed sender gaps and receiver stalls up to 63 percent, "
                 , "plus a long output hold and a mid-frame pause");
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout waiting for results");
        $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lpd_pkg.sv
rtl/lpd_front.sv
rtl/lpd_queue.sv
rtl/lpd_out_reg.sv
rtl/length_prefix_deframer.sv
verif/length_prefix_deframer_tb.sv
